/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks of the reception tracker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define RRCT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every rising edge, reset included
`define RRCT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/rrct_pkg.sv */
// ----------------------------------------------------------------------------
// rrct_pkg
// Types, codes and the collision test shared by the reception tracker.
// ----------------------------------------------------------------------------
package rrct_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int NODE_BITS_DEF   = 8;
    localparam int RESULT_LIMIT    = 16;
    localparam int RES_CNT_W       = $clog2(RESULT_LIMIT + 1);

    // Operation codes
    localparam logic [1:0] OP_RX   = 2'd0;
    localparam logic [1:0] OP_TX   = 2'd1;
    localparam logic [1:0] OP_TIME = 2'd2;

    // Status codes
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_DELIVERED = 3'd1;
    localparam logic [2:0] ST_COLLIDED  = 3'd2;
    localparam logic [2:0] ST_LOST      = 3'd3;
    localparam logic [2:0] ST_HALFDUP   = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    // Entry flag bits
    localparam int FL_COLLIDED = 0;
    localparam int FL_LOST     = 1;
    localparam int FL_ABORT    = 2;

    // Configuration register indexes
    localparam logic [2:0] CFG_MARGIN = 3'd0;
    localparam logic [2:0] CFG_GRACE  = 3'd1;
    localparam logic [2:0] CFG_FEC    = 3'd2;
    localparam logic [2:0] CFG_PRE    = 3'd3;

    localparam logic [7:0] MARGIN_RST = 8'd24;

    // One classified event as queued between front and back
    typedef struct packed {
        logic [1:0]        op;
        logic [31:0]       now;
        logic [31:0]       end_ms;
        logic signed [9:0] snr;
        logic [7:0]        sender;
        logic [15:0]       tag;
        logic              lost;
    } cmd_t;

    // Is the victim destroyed by the interferer?
    function automatic logic destroyed(
        input logic [31:0]       vs,
        input logic [31:0]       ve,
        input logic signed [9:0] vsnr,
        input logic [31:0]       i_s,
        input logic [31:0]       ie,
        input logic signed [9:0] isnr,
        input logic [7:0]        margin,
        input logic [15:0]       grace,
        input logic [15:0]       fec,
        input logic [15:0]       pre
    );
        logic [31:0]        os;
        logic [31:0]        oe;
        logic signed [11:0] v12;
        logic signed [11:0] thr;
        logic               res;
        os  = (vs > i_s) ? vs : i_s;
        oe  = (ve < ie) ? ve : ie;
        v12 = {{2{vsnr[9]}}, vsnr};
        thr = {{2{isnr[9]}}, isnr} + $signed({4'b0000, margin});
        res = 1'b1;
        if (ie <= vs || ve <= i_s) begin
            res = 1'b0;
        end else if (v12 >= thr) begin
            res = 1'b0;
        end else if ({1'b0, ie} <= ({1'b0, vs} + {17'd0, grace})) begin
            res = 1'b0;
        end else if (fec != 16'd0 && (oe - os) <= {16'd0, fec} &&
                     {1'b0, os} >= ({1'b0, vs} + {17'd0, pre})) begin
            res = 1'b0;
        end
        return res;
    endfunction

endpackage

/* rtl/rrct_front.sv */
// ----------------------------------------------------------------------------
// rrct_front
// Accepts input beats, classifies them and holds them in a two-deep queue.
// ----------------------------------------------------------------------------
module rrct_front #(
    parameter int NODE_BITS = rrct_pkg::NODE_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [87:0]         s_tdata,
    input  logic [2:0]          s_tuser,
    output logic                q_valid,
    input  logic                q_pop,
    output rrct_pkg::cmd_t      q_cmd
);
    import rrct_pkg::*;

    localparam int SB = (NODE_BITS < 8) ? NODE_BITS : 8;

    cmd_t        q_mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push;
    cmd_t        cls;
    logic [32:0] end_sum;
    logic [7:0]  snd;

    // Classify: unpack, mask the sender, saturate the end time
    always_comb begin
        snd         = s_tdata[65:58];
        end_sum     = {1'b0, s_tdata[31:0]} + {17'd0, s_tdata[47:32]};
        cls.op      = s_tuser[1:0];
        cls.now     = s_tdata[31:0];
        cls.end_ms  = end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];
        cls.snr     = $signed(s_tdata[57:48]);
        cls.sender  = 8'(snd[SB-1:0]);
        cls.tag     = s_tdata[81:66];
        cls.lost    = s_tuser[2];
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = q_mem[rd_ptr_reg];

    // Advance queue pointers
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

/* rtl/rrct_back.sv */
// ----------------------------------------------------------------------------
// rrct_back
// Walks the reception table one entry a cycle per event, pausing while a time check waits on the m_ side.
// ----------------------------------------------------------------------------
module rrct_back #(
    parameter int TABLE_DEPTH = rrct_pkg::TABLE_DEPTH_DEF,
    parameter int NODE_BITS   = rrct_pkg::NODE_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_addr,
    input  logic [15:0]         cfg_wdata,
    input  logic                q_valid,
    output logic                q_pop,
    input  rrct_pkg::cmd_t      q_cmd,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [71:0]         m_tdata,
    output logic [2:0]          m_tuser,
    output logic                m_tlast
);
    import rrct_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SB = (NODE_BITS < 8) ? NODE_BITS : 8;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    // Configuration
    logic [7:0]  margin_reg;
    logic [15:0] grace_reg, fec_reg, pre_reg;

    // Table
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [31:0]       start_mem  [TABLE_DEPTH];
    logic [31:0]       end_mem    [TABLE_DEPTH];
    logic signed [9:0] snr_mem    [TABLE_DEPTH];
    logic [SB-1:0]     sender_mem [TABLE_DEPTH];
    logic [15:0]       tag_mem    [TABLE_DEPTH];
    logic [2:0]        flags_mem  [TABLE_DEPTH];

    // Sequencer
    logic [1:0]           state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic [IW-1:0]        slot_reg, slot_next;
    logic [31:0]          busy_reg, busy_next;
    logic [RES_CNT_W-1:0] n_reg, n_next;
    logic [2:0]           nflags_reg, nflags_next;

    // Pending result
    logic              held_reg, held_next;
    logic [2:0]        rs_status_reg, rs_status_next;
    logic [7:0]        rs_sender_reg, rs_sender_next;
    logic [15:0]       rs_tag_reg, rs_tag_next;
    logic signed [9:0] rs_snr_reg, rs_snr_next;
    logic [31:0]       rs_start_reg, rs_start_next;

    // Output register
    logic              mv_reg, mv_next;
    logic [2:0]        mo_status_reg;
    logic [7:0]        mo_sender_reg;
    logic [15:0]       mo_tag_reg;
    logic signed [9:0] mo_snr_reg;
    logic [31:0]       mo_start_reg;
    logic              mo_last_reg;

    logic              out_load, out_last, out_free;
    logic              out_zero;
    logic              flag_we, clr_valid, wr_slot;
    logic [2:0]        flag_set;
    logic [IW-1:0]     free_idx;
    logic              any_free;
    logic              e_valid, expired, is_last, kill_new, kill_old;
    logic [31:0]       e_start, e_end;
    logic signed [9:0] e_snr;
    logic [2:0]        e_flags;
    logic [2:0]        e_status;

    // Find the lowest free entry
    always_comb begin
        free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = IW'(i);
            end
        end
        any_free = ~&valid_reg;
    end

    // Read the entry under the scan pointer
    always_comb begin
        e_valid  = valid_reg[idx_reg];
        e_start  = start_mem[idx_reg];
        e_end    = end_mem[idx_reg];
        e_snr    = snr_mem[idx_reg];
        e_flags  = flags_mem[idx_reg];
        expired  = e_valid && (e_end <= cmd_reg.now);
        is_last  = (idx_reg == LAST_IDX);
        kill_new = destroyed(cmd_reg.now, cmd_reg.end_ms, cmd_reg.snr, e_start, e_end,
                             e_snr, margin_reg, grace_reg, fec_reg, pre_reg);
        kill_old = destroyed(e_start, e_end, e_snr, cmd_reg.now, cmd_reg.end_ms,
                             cmd_reg.snr, margin_reg, grace_reg, fec_reg, pre_reg);
        if (e_flags[FL_ABORT]) begin
            e_status = ST_HALFDUP;
        end else if (e_flags[FL_LOST]) begin
            e_status = ST_LOST;
        end else if (e_flags[FL_COLLIDED]) begin
            e_status = ST_COLLIDED;
        end else begin
            e_status = ST_DELIVERED;
        end
    end

    assign out_free = !mv_reg || m_tready;

    // Sequence one event over the table
    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        slot_next      = slot_reg;
        busy_next      = busy_reg;
        n_next         = n_reg;
        nflags_next    = nflags_reg;
        held_next      = held_reg;
        rs_status_next = rs_status_reg;
        rs_sender_next = rs_sender_reg;
        rs_tag_next    = rs_tag_reg;
        rs_snr_next    = rs_snr_reg;
        rs_start_next  = rs_start_reg;
        q_pop          = 1'b0;
        out_load       = 1'b0;
        out_last       = 1'b0;
        out_zero       = 1'b0;
        flag_we        = 1'b0;
        flag_set       = 3'b000;
        clr_valid      = 1'b0;
        wr_slot        = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop          = 1'b1;
                    cmd_next       = q_cmd;
                    idx_next       = '0;
                    n_next         = '0;
                    held_next      = 1'b0;
                    nflags_next    = {1'b0, q_cmd.lost, 1'b0};
                    rs_sender_next = q_cmd.sender;
                    rs_tag_next    = q_cmd.tag;
                    rs_snr_next    = q_cmd.snr;
                    rs_start_next  = q_cmd.now;
                    case (q_cmd.op)
                        OP_RX: begin
                            if (busy_reg > q_cmd.now) begin
                                held_next      = 1'b1;
                                rs_status_next = ST_HALFDUP;
                                state_next     = S_FLUSH;
                            end else if (!any_free) begin
                                held_next      = 1'b1;
                                rs_status_next = ST_FULL;
                                state_next     = S_FLUSH;
                            end else begin
                                slot_next  = free_idx;
                                state_next = S_SCAN;
                            end
                        end
                        OP_TX: begin
                            if (q_cmd.end_ms > busy_reg) begin
                                busy_next = q_cmd.end_ms;
                            end
                            state_next = S_SCAN;
                        end
                        OP_TIME: begin
                            state_next = S_SCAN;
                        end
                        default: begin
                            state_next = S_FLUSH;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                case (cmd_reg.op)
                    OP_RX: begin
                        if (e_valid && kill_old) begin
                            flag_we  = 1'b1;
                            flag_set = 3'b001 << FL_COLLIDED;
                        end
                        if (e_valid && kill_new) begin
                            nflags_next[FL_COLLIDED] = 1'b1;
                        end
                        idx_next = idx_reg + 1'b1;
                        if (is_last) begin
                            wr_slot        = 1'b1;
                            held_next      = 1'b1;
                            rs_status_next = ST_IDLE;
                            state_next     = S_FLUSH;
                        end
                    end
                    OP_TX: begin
                        if (e_valid && e_end > cmd_reg.now) begin
                            flag_we  = 1'b1;
                            flag_set = 3'b001 << FL_ABORT;
                        end
                        idx_next = idx_reg + 1'b1;
                        if (is_last) begin
                            state_next = S_FLUSH;
                        end
                    end
                    default: begin
                        // Retire expired entries, one result held back for tlast
                        if (!(expired && held_reg && !out_free)) begin
                            if (expired) begin
                                out_load       = held_reg;
                                held_next      = 1'b1;
                                rs_status_next = e_status;
                                rs_sender_next = 8'(sender_mem[idx_reg]);
                                rs_tag_next    = tag_mem[idx_reg];
                                rs_snr_next    = e_snr;
                                rs_start_next  = e_start;
                                clr_valid      = 1'b1;
                                n_next         = n_reg + 1'b1;
                            end
                            idx_next = idx_reg + 1'b1;
                            if (is_last || (expired &&
                                (n_reg + 1'b1) == RES_CNT_W'(RESULT_LIMIT))) begin
                                state_next = S_FLUSH;
                            end
                        end
                    end
                endcase
            end
            S_FLUSH: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_last   = 1'b1;
                    out_zero   = !held_reg;
                    held_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Valid bits
    always_comb begin
        valid_next = valid_reg;
        if (clr_valid) begin
            valid_next[idx_reg] = 1'b0;
        end
        if (wr_slot) begin
            valid_next[slot_reg] = 1'b1;
        end
        mv_next = out_load ? 1'b1 : (m_tready ? 1'b0 : mv_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            valid_reg  <= '0;
            busy_reg   <= '0;
            held_reg   <= 1'b0;
            mv_reg     <= 1'b0;
            margin_reg <= MARGIN_RST;
            grace_reg  <= '0;
            fec_reg    <= '0;
            pre_reg    <= '0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            busy_reg  <= busy_next;
            held_reg  <= held_next;
            mv_reg    <= mv_next;
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_MARGIN: margin_reg <= cfg_wdata[7:0];
                    CFG_GRACE:  grace_reg  <= cfg_wdata;
                    CFG_FEC:    fec_reg    <= cfg_wdata;
                    CFG_PRE:    pre_reg    <= cfg_wdata;
                    default:    ;
                endcase
            end
        end
    end

    // Payload registers and table contents
    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        idx_reg       <= idx_next;
        slot_reg      <= slot_next;
        n_reg         <= n_next;
        nflags_reg    <= nflags_next;
        rs_status_reg <= rs_status_next;
        rs_sender_reg <= rs_sender_next;
        rs_tag_reg    <= rs_tag_next;
        rs_snr_reg    <= rs_snr_next;
        rs_start_reg  <= rs_start_next;
        if (flag_we) begin
            flags_mem[idx_reg] <= e_flags | flag_set;
        end
        if (wr_slot) begin
            start_mem[slot_reg]  <= cmd_reg.now;
            end_mem[slot_reg]    <= cmd_reg.end_ms;
            snr_mem[slot_reg]    <= cmd_reg.snr;
            sender_mem[slot_reg] <= cmd_reg.sender[SB-1:0];
            tag_mem[slot_reg]    <= cmd_reg.tag;
            // Include the verdict against the final entry of the walk
            flags_mem[slot_reg]  <= nflags_next;
        end
        if (out_load) begin
            mo_status_reg <= out_zero ? ST_IDLE : rs_status_reg;
            mo_sender_reg <= out_zero ? 8'd0 : rs_sender_reg;
            mo_tag_reg    <= out_zero ? 16'd0 : rs_tag_reg;
            mo_snr_reg    <= out_zero ? 10'sd0 : rs_snr_reg;
            mo_start_reg  <= out_zero ? 32'd0 : rs_start_reg;
            mo_last_reg   <= out_last;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tuser  = mo_status_reg;
    assign m_tlast  = mo_last_reg;
    assign m_tdata  = {6'd0, mo_start_reg, mo_snr_reg, mo_tag_reg, mo_sender_reg};

endmodule

/* rtl/radio_reception_collision_tracker_top.sv */
// ----------------------------------------------------------------------------
// radio_reception_collision_tracker_top
// Reception table of one receiver with capture, grace and FEC collision rules.
// ----------------------------------------------------------------------------
// An event is a beat on the s_ side: a new reception, an own transmission or
// a time check. A front stage queues up to two classified events while the
// back engine walks the table one entry a cycle, pausing while a time check
// waits on the m_ side; a reception dropped for half-duplex or a full table
// skips the walk. A time check yields one beat per retired entry in index
// order (at most 16), the final one with tlast, or a single zeroed beat if
// none retire; every other event yields a single beat with tlast.
module radio_reception_collision_tracker_top #(
    parameter int TABLE_DEPTH = rrct_pkg::TABLE_DEPTH_DEF,
    parameter int NODE_BITS   = rrct_pkg::NODE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // now_ms, duration, rx_snr, sender_id, packet_tag (low bit up)
    input  logic [87:0] s_tdata,
    // operation, link_lost (low bit up)
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_sender, out_tag, out_snr, out_start_ms (low bit up)
    output logic [71:0] m_tdata,
    // status
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);
    import rrct_pkg::*;

    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    rrct_front #(
        .NODE_BITS(NODE_BITS)
    ) u_front (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .q_valid(q_valid),
        .q_pop(q_pop),
        .q_cmd(q_cmd)
    );

    rrct_back #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .NODE_BITS(NODE_BITS)
    ) u_back (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .q_valid(q_valid),
        .q_pop(q_pop),
        .q_cmd(q_cmd),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

endmodule

/* rtl/rrct_checker.sv */
// ----------------------------------------------------------------------------
// rrct_checker
// Port-level checks of the reception tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrct_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);
    import rrct_pkg::*;

    // Hold a stalled result beat
    `RRCT_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")
    // Status stays within its codes
    `RRCT_ASSERT(a_status, aclk, aresetn, m_tvalid |-> m_tuser <= ST_FULL, "bad status code")
    // A table-full drop is always a single beat
    `RRCT_ASSERT(a_full_last, aclk, aresetn, m_tvalid && m_tuser == ST_FULL |-> m_tlast, "table-full beat without tlast")
    // No result straight after reset
    `RRCT_ASSERT_ALWAYS(a_rst, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind radio_reception_collision_tracker_top rrct_checker u_rrct_checker (.*);
